/* rtl/rhht_pkg.sv */
// Shared constants and types for the Robin Hood hash table unit.
package rhht_pkg;
   localparam int NumSlotsDef  = 1024;
   localparam int DataWidthDef = 64;
   localparam int MaxProbeDef  = 63;
   localparam int CountW       = 11;
   localparam logic [CountW-1:0] MaxOccReset = 11'd768;

   typedef enum logic [1:0] {
      OP_SET   = 2'd0,
      OP_GET   = 2'd1,
      OP_ERASE = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_OVERFLOW  = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   localparam logic [0:0] REG_MAX_OCC = 1'b0;
endpackage

/* rtl/rhht_csr.sv */
// Configuration register file holding the occupancy limit.
module rhht_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [0:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready,
   output logic [rhht_pkg::CountW-1:0] max_occ
);
   import rhht_pkg::*;

   logic [CountW-1:0] max_occ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_occ_ff <= MaxOccReset;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_MAX_OCC) begin
         max_occ_ff <= csr_pwdata[CountW-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_MAX_OCC) ? {{(32-CountW){1'b0}}, max_occ_ff} : 32'd0;
   assign max_occ    = max_occ_ff;
endmodule

/* rtl/rhht_slot_ram.sv */
// Slot storage: per-slot flags, probe distance, key and data memories.
module rhht_slot_ram #(
   parameter int NUM_SLOTS  = rhht_pkg::NumSlotsDef,
   parameter int DATA_WIDTH = rhht_pkg::DataWidthDef,
   parameter int DistW      = 6,
   parameter int AddrW      = $clog2(NUM_SLOTS)
) (
   input  logic                  clock,
   input  logic [AddrW-1:0]      rd_addr,
   output logic                  rd_occ,
   output logic                  rd_tomb,
   output logic [DistW-1:0]      rd_dist,
   output logic [31:0]           rd_key,
   output logic [DATA_WIDTH-1:0] rd_data,
   input  logic                  wr_en,
   input  logic [AddrW-1:0]      wr_addr,
   input  logic                  wr_occ,
   input  logic                  wr_tomb,
   input  logic [DistW-1:0]      wr_dist,
   input  logic [31:0]           wr_key,
   input  logic [DATA_WIDTH-1:0] wr_data
);
   logic                  occ_mem  [NUM_SLOTS];
   logic                  tomb_mem [NUM_SLOTS];
   logic [DistW-1:0]      dist_mem [NUM_SLOTS];
   logic [31:0]           key_mem  [NUM_SLOTS];
   logic [DATA_WIDTH-1:0] data_mem [NUM_SLOTS];

   // flags are cleared by the sequencer's pass after reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         occ_mem[wr_addr]  <= wr_occ;
         tomb_mem[wr_addr] <= wr_tomb;
         dist_mem[wr_addr] <= wr_dist;
         key_mem[wr_addr]  <= wr_key;
         data_mem[wr_addr] <= wr_data;
      end
      rd_occ  <= occ_mem[rd_addr];
      rd_tomb <= tomb_mem[rd_addr];
      rd_dist <= dist_mem[rd_addr];
      rd_key  <= key_mem[rd_addr];
      rd_data <= data_mem[rd_addr];
   end
endmodule

/* rtl/robin_hood_hash_table_unit.sv */
// Top level of the Robin Hood hash table unit: probe sequencer and ports.
// One transaction at a time. After reset the block walks every slot once to
// clear its flags, with req_tready low. Each probe step reads one slot through
// the single registered read port: an address step, then a compare/update step.
// A get or erase visits at most MAX_PROBE+1 slots. A set of a new key runs a
// lookup pass and then an insert pass. A long chain of displacements can run
// the insert pass past MAX_PROBE+1 slots, up to NUM_SLOTS*(MAX_PROBE+2) slots.
// After a result is taken on rsp_ the block is ready again; max_occupied is at
// csr address 0. NUM_SLOTS must be a power of two: the home slot is the key's
// low bits.
module robin_hood_hash_table_unit #(
   parameter int NUM_SLOTS  = rhht_pkg::NumSlotsDef,
   parameter int DATA_WIDTH = rhht_pkg::DataWidthDef,
   parameter int MAX_PROBE  = rhht_pkg::MaxProbeDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [103:0] req_tdata,  // key[31:0], value[95:32], zero[103:96]
   input  logic [1:0]  req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // found[0], read_value[64:1], entry_count[75:65], zero
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rhht_pkg::*;

   localparam int AddrW  = $clog2(NUM_SLOTS);
   localparam int DistW  = $clog2(MAX_PROBE + 2);
   localparam int StepW  = $clog2(NUM_SLOTS * (MAX_PROBE + 2) + 1);
   localparam logic [AddrW-1:0] LastSlot = AddrW'(NUM_SLOTS - 1);
   localparam logic [DistW-1:0] MaxDist  = DistW'(MAX_PROBE);
   localparam logic [StepW-1:0] StepLimit = StepW'(NUM_SLOTS * (MAX_PROBE + 2));

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_LREAD, S_LCHECK, S_IREAD, S_ICHECK, S_DONE
   } state_type;

   state_type             state_ff, state_in;
   opcode_type            op_ff, op_in;
   logic [31:0]           key_ff, key_in;
   logic [DATA_WIDTH-1:0] hd_ff, hd_in;
   logic [31:0]           hk_ff, hk_in;
   logic [DistW-1:0]      pd_ff, pd_in;
   logic [AddrW-1:0]      idx_ff, idx_in;
   logic [StepW-1:0]      step_ff, step_in;
   logic [CountW-1:0]     cnt_ff, cnt_in;
   status_type            st_ff, st_in;
   logic                  found_ff, found_in;
   logic [DATA_WIDTH-1:0] rv_ff, rv_in;

   logic [CountW-1:0]     max_occ;
   logic                  r_occ, r_tomb;
   logic [DistW-1:0]      r_dist;
   logic [31:0]           r_key;
   logic [DATA_WIDTH-1:0] r_data;
   logic                  w_en, w_occ, w_tomb;
   logic [DistW-1:0]      w_dist;
   logic [31:0]           w_key;
   logic [DATA_WIDTH-1:0] w_data;
   logic [AddrW-1:0]      idx_next, home;

   rhht_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite,
      .csr_paddr(csr_paddr[2]), .csr_pwdata, .csr_prdata, .csr_pready, .max_occ
   );

   rhht_slot_ram #(.NUM_SLOTS(NUM_SLOTS), .DATA_WIDTH(DATA_WIDTH), .DistW(DistW)) u_ram (
      .clock, .rd_addr(idx_ff), .rd_occ(r_occ), .rd_tomb(r_tomb),
      .rd_dist(r_dist), .rd_key(r_key), .rd_data(r_data),
      .wr_en(w_en), .wr_addr(idx_ff), .wr_occ(w_occ), .wr_tomb(w_tomb),
      .wr_dist(w_dist), .wr_key(w_key), .wr_data(w_data)
   );

   assign idx_next = (idx_ff == LastSlot) ? '0 : idx_ff + 1'b1;
   assign home     = req_tdata[AddrW-1:0];

   always_comb begin
      state_in = state_ff; op_in = op_ff; key_in = key_ff; hd_in = hd_ff;
      hk_in = hk_ff; pd_in = pd_ff; idx_in = idx_ff; step_in = step_ff;
      cnt_in = cnt_ff; st_in = st_ff; found_in = found_ff; rv_in = rv_ff;
      w_en = 1'b0; w_occ = 1'b1; w_tomb = 1'b0; w_dist = pd_ff;
      w_key = hk_ff; w_data = hd_ff;
      case (state_ff)
         S_CLEAR: begin
            // mark every slot empty, one per cycle
            w_en = 1'b1; w_occ = 1'b0; w_tomb = 1'b0;
            idx_in = idx_next;
            if (idx_ff == LastSlot) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = opcode_type'(req_tuser);
               key_in   = req_tdata[31:0];
               hk_in    = req_tdata[31:0];
               hd_in    = req_tdata[32 +: DATA_WIDTH];
               idx_in   = home;
               pd_in    = '0;
               step_in  = '0;
               st_in    = ST_OK;
               found_in = 1'b0;
               rv_in    = '0;
               state_in = (opcode_type'(req_tuser) == OP_NOP) ? S_DONE : S_LREAD;
            end
         end
         S_LREAD: state_in = S_LCHECK;
         S_LCHECK: begin
            if (r_occ && !r_tomb && r_key == key_ff) begin
               found_in = 1'b1;
               state_in = S_DONE;
               if (op_ff == OP_SET) begin
                  w_en = 1'b1; w_occ = 1'b1; w_tomb = 1'b0; w_dist = r_dist;
                  w_key = r_key; w_data = hd_ff;
               end else if (op_ff == OP_GET) begin
                  rv_in = r_data;
               end else begin
                  w_en = 1'b1; w_occ = 1'b0; w_tomb = 1'b1; w_dist = r_dist;
                  w_key = r_key; w_data = r_data;
                  cnt_in = cnt_ff - 1'b1;
               end
            end else if ((!r_occ && !r_tomb) || pd_ff == MaxDist) begin
               // miss: key absent
               if (op_ff != OP_SET) begin
                  st_in = ST_NOT_FOUND; state_in = S_DONE;
               end else if (cnt_ff >= max_occ) begin
                  st_in = ST_FULL; state_in = S_DONE;
               end else begin
                  idx_in = key_ff[AddrW-1:0];
                  pd_in = '0;
                  state_in = S_IREAD;
               end
            end else begin
               pd_in = pd_ff + 1'b1;
               idx_in = idx_next;
               state_in = S_LREAD;
            end
         end
         S_IREAD: begin
            if ({1'b0, pd_ff} > {1'b0, MaxDist} || step_ff >= StepLimit) begin
               st_in = ST_OVERFLOW; state_in = S_DONE;
            end else begin
               state_in = S_ICHECK;
            end
         end
         S_ICHECK: begin
            step_in = step_ff + 1'b1;
            idx_in  = idx_next;
            if (!r_occ) begin
               w_en = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               state_in = S_DONE;
            end else if (pd_ff <= r_dist) begin
               pd_in = pd_ff + 1'b1;
               state_in = S_IREAD;
            end else begin
               // swap: park the entry in hand, carry the resident on
               w_en = 1'b1;
               hk_in = r_key; hd_in = r_data;
               pd_in = r_dist + 1'b1;
               state_in = S_IREAD;
            end
         end
         S_DONE: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         st_ff    <= ST_OK;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         st_ff    <= st_in;
         found_ff <= found_in;
      end
      op_ff <= op_in; key_ff <= key_in; hd_ff <= hd_in; hk_ff <= hk_in;
      pd_ff <= pd_in; step_ff <= step_in; rv_ff <= rv_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_DONE);
   assign rsp_tuser  = st_ff;
   assign rsp_tdata  = {4'd0, cnt_ff, 64'(rv_ff), found_ff};

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CountW'(NUM_SLOTS)) else $error("entry count above slot count");
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while a result waits");
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && found_ff |-> st_ff == ST_OK) else $error("found with bad status");
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready && $past(req_tready) |-> $stable(cnt_ff)) else $error("count moved idle");
`endif
endmodule

/* tb/testbench.sv */
// Self-checking testbench for the Robin Hood hash table unit.
`timescale 1ns / 100ps

module testbench;
   import rhht_pkg::*;

   localparam int NSLOT  = 1024;
   localparam int MAXPRB = 63;
   localparam longint STEP_CAP = 1024 * 65;

   typedef struct packed {
      opcode_type  op;
      logic [31:0] key;
      logic [63:0] value;
   } table_req_type;

   typedef struct packed {
      status_type  status;
      logic        found;
      logic [63:0] read_value;
      logic [10:0] entry_count;
   } table_rsp_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   robin_hood_hash_table_unit dut (.*);

   always #4 clock = ~clock;

   // mirror of the table
   logic        mir_occ [NSLOT];
   logic        mir_tomb [NSLOT];
   logic [5:0]  mir_dist [NSLOT];
   logic [31:0] mir_key [NSLOT];
   logic [63:0] mir_data [NSLOT];
   int unsigned mir_count;
   int unsigned mir_limit;

   table_req_type pending_reqs[$];
   table_rsp_type expected_rsps[$];
   logic [31:0] live_keys[$];
   int  errors = 0;
   bit  calm = 0;     // no idling on either side
   bit  hold_off = 0;

   function automatic bit find_slot(input logic [31:0] k, output int where);
      int i;
      i = k % NSLOT;
      where = 0;
      for (int n = 0; n <= MAXPRB; n++) begin
         if (mir_tomb[i]) begin
            i = (i + 1) % NSLOT;
         end else if (mir_occ[i]) begin
            if (mir_key[i] == k) begin
               where = i;
               return 1;
            end
            i = (i + 1) % NSLOT;
         end else begin
            return 0;
         end
      end
      return 0;
   endfunction

   function automatic status_type place_entry(input logic [31:0] k, input logic [63:0] d);
      logic [31:0] hk, ek;
      logic [63:0] hd, ed;
      int unsigned pd, epd;
      int i;
      longint steps;
      hk = k; hd = d; pd = 0; i = k % NSLOT; steps = 0;
      forever begin
         if (pd > MAXPRB || steps >= STEP_CAP) return ST_OVERFLOW;
         steps++;
         if (mir_occ[i]) begin
            if (pd <= mir_dist[i]) begin
               pd++;
            end else begin
               ek = mir_key[i]; ed = mir_data[i]; epd = mir_dist[i];
               mir_key[i] = hk; mir_data[i] = hd; mir_tomb[i] = 0;
               mir_dist[i] = pd[5:0];
               hk = ek; hd = ed; pd = epd + 1;
            end
            i = (i + 1) % NSLOT;
         end else begin
            mir_key[i] = hk; mir_data[i] = hd; mir_occ[i] = 1; mir_tomb[i] = 0;
            mir_dist[i] = pd[5:0];
            mir_count++;
            return ST_OK;
         end
      end
   endfunction

   function automatic table_rsp_type apply_request(input table_req_type r);
      table_rsp_type o;
      int at;
      o = '{status: ST_OK, found: 0, read_value: '0, entry_count: '0};
      case (r.op)
         OP_SET: begin
            if (find_slot(r.key, at)) begin
               mir_data[at] = r.value;
               o.found = 1;
            end else if (mir_count >= mir_limit) begin
               o.status = ST_FULL;
            end else begin
               o.status = place_entry(r.key, r.value);
            end
         end
         OP_GET: begin
            if (find_slot(r.key, at)) begin
               o.found = 1;
               o.read_value = mir_data[at];
            end else begin
               o.status = ST_NOT_FOUND;
            end
         end
         OP_ERASE: begin
            if (find_slot(r.key, at)) begin
               o.found = 1;
               mir_occ[at] = 0;
               mir_tomb[at] = 1;
               mir_count--;
            end else begin
               o.status = ST_NOT_FOUND;
            end
         end
         default: ;
      endcase
      o.entry_count = mir_count[10:0];
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid && req_tready)
            expected_rsps.push_back(apply_request(pending_reqs.pop_front()));
         if (pending_reqs.size() > 0 && !hold_off
             && (calm || $urandom_range(99) >= 26)) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_reqs[0].op;
            req_tdata  <= {8'h00, pending_reqs[0].value, pending_reqs[0].key};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      table_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result transaction");
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_tuser != want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[0] != want.found) begin
                  $error("found expected %0d got %0d", want.found, rsp_tdata[0]);
                  errors++;
               end
               if (rsp_tdata[64:1] != want.read_value) begin
                  $error("read_value expected %h got %h", want.read_value,
                         rsp_tdata[64:1]);
                  errors++;
               end
               if (rsp_tdata[75:65] != want.entry_count) begin
                  $error("entry_count expected %0d got %0d", want.entry_count,
                         rsp_tdata[75:65]);
                  errors++;
               end
            end
         end
         rsp_tready <= calm || ($urandom_range(99) >= 26);
      end
   end

   task automatic write_limit(input logic [31:0] v);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {REG_MAX_OCC, 2'b00}; csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      mir_limit = v & 32'h7FF;
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_key(input int unsigned span);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 55 && live_keys.size() > 0)
         return live_keys[$urandom_range(live_keys.size() - 1)];
      if (r < 90)  // cluster homes to build long probe chains
         return {22'($urandom_range(7)), 10'($urandom_range(span))};
      return $urandom;
   endfunction

   task automatic queue_op(input opcode_type op, input logic [31:0] k,
                           input logic [63:0] v);
      pending_reqs.push_back('{op: op, key: k, value: v});
      if (op == OP_SET) live_keys.push_back(k);
      if (live_keys.size() > 400) void'(live_keys.pop_front());
   endtask

   task automatic random_phase(input int n, input int unsigned span);
      int unsigned r;
      for (int j = 0; j < n; j++) begin
         r = $urandom_range(99);
         queue_op(r < 50 ? OP_SET : r < 75 ? OP_GET : r < 97 ? OP_ERASE : OP_NOP,
                  pick_key(span), {$urandom, $urandom});
      end
   endtask

   initial begin
      for (int i = 0; i < NSLOT; i++) begin
         mir_occ[i] = 0; mir_tomb[i] = 0; mir_dist[i] = 0;
         mir_key[i] = 0; mir_data[i] = 0;
      end
      mir_count = 0;
      mir_limit = MaxOccReset;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every opcode, not-found, overwrite, tombstone reuse
      queue_op(OP_GET, 32'h0, '0);
      queue_op(OP_ERASE, 32'hFFFF_FFFF, '0);
      queue_op(OP_SET, 32'h0, '0);
      queue_op(OP_SET, 32'hFFFF_FFFF, '1);
      queue_op(OP_SET, 32'h0000_0400, 64'h5555_5555_5555_5555);
      queue_op(OP_SET, 32'h0000_0800, 64'hAAAA_AAAA_AAAA_AAAA);
      queue_op(OP_GET, 32'h0000_0800, '0);
      queue_op(OP_SET, 32'h0, 64'h1234);
      queue_op(OP_GET, 32'h0, '0);
      queue_op(OP_ERASE, 32'h0000_0400, '0);
      queue_op(OP_GET, 32'h0000_0800, '0);
      queue_op(OP_SET, 32'h0000_0001, 64'h1);
      queue_op(OP_SET, 32'h0000_0C00, 64'h2);
      queue_op(OP_GET, 32'hFFFF_FFFF, '0);
      queue_op(OP_NOP, 32'hFFFF_FFFF, '1);
      queue_op(OP_ERASE, 32'hFFFF_FFFF, '0);
      drain();

      // zero limit: every new insert full
      write_limit(0);
      queue_op(OP_SET, 32'h1234_5678, 64'h9);
      queue_op(OP_SET, 32'h0000_0800, 64'h7);
      drain();

      write_limit(1024);
      // probe overflow: 70 keys on one home slot
      for (int j = 0; j < 70; j++) queue_op(OP_SET, {22'(j), 10'h3F0}, 64'(j));
      calm = 1;
      random_phase(300, 15);
      drain();
      calm = 0;

      write_limit(5);
      random_phase(150, 31);
      drain();

      write_limit(32'hFFFF_F9FF);   // upper bits dropped
      random_phase(600, 63);
      // pause the sender until all results are back
      while (pending_reqs.size() > 0 || req_tvalid) @(posedge clock);
      hold_off = 1;
      while (expected_rsps.size() > 0) @(posedge clock);
      hold_off = 0;
      random_phase(800, 1023);
      drain();

      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("TB_ERROR");
      $finish;
   end
endmodule
